// ===== sv/sensor_poll_scheduler_macros.svh =====
// Assertion macros for the sensor poll scheduler.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef SENSOR_POLL_SCHEDULER_MACROS_SVH
`define SENSOR_POLL_SCHEDULER_MACROS_SVH

// same-cycle implication
`define SPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sps assertion failed");

// next-cycle implication
`define SPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sps assertion failed");

`endif

// ===== sv/sps_pkg.sv =====
// Shared types and codes for the sensor poll scheduler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sps_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned ValW  = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [1:0] PH_OFF  = 2'd0;
  localparam logic [1:0] PH_WAIT = 2'd1;
  localparam logic [1:0] PH_READ = 2'd2;
  localparam logic [1:0] PH_SEND = 2'd3;

  localparam logic [1:0] OP_LOOP    = 2'd0;
  localparam logic [1:0] OP_START   = 2'd1;
  localparam logic [1:0] OP_TERM    = 2'd2;
  localparam logic [1:0] OP_SETWAIT = 2'd3;

  localparam logic [CfgIdxW-1:0] CFG_READ_INTERVAL   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RESEND_INTERVAL = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_WARMUP          = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_RESTART_ENABLE  = 2'd3;

  typedef struct packed {
    logic [TimeW-1:0] read_interval_ms;
    logic [TimeW-1:0] resend_interval_ms;
    logic [TimeW-1:0] warmup_ms;
    logic             restart_enable;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [TimeW-1:0] now_ms;
    logic             probe_done;
    logic             probe_has_value;
    logic [ValW-1:0]  probe_value;
    logic [TimeW-1:0] pause_ms;
  } item_t;

  typedef struct packed {
    logic            send_now;
    logic [ValW-1:0] send_value;
    logic [1:0]      phase;
    logic            pausing;
    logic            active;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/sps_cfg_regs.sv =====
// Configuration register file of the sensor poll scheduler.
// Depends on sps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sps_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [sps_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [sps_pkg::TimeW-1:0]   cfg_data_i,
  output sps_pkg::cfg_t                    cfg_o
);
  import sps_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_READ_INTERVAL:   cfg_q.read_interval_ms   <= cfg_data_i;
        CFG_RESEND_INTERVAL: cfg_q.resend_interval_ms <= cfg_data_i;
        CFG_WARMUP:          cfg_q.warmup_ms          <= cfg_data_i;
        CFG_RESTART_ENABLE:  cfg_q.restart_enable     <= cfg_data_i[0];
        default:             cfg_q                    <= cfg_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/sps_core.sv =====
// Scheduler state and single-pass step logic of the sensor poll scheduler.
// Depends on sps_pkg and sensor_poll_scheduler_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "sensor_poll_scheduler_macros.svh"
module sps_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire sps_pkg::item_t item_i,
  input  wire sps_pkg::cfg_t  cfg_i,
  output sps_pkg::res_t       res_o
);
  import sps_pkg::*;

  logic [1:0]       phase_q, phase_d;
  logic             active_q, active_d;
  logic [TimeW-1:0] last_read_q, last_read_d;
  logic [TimeW-1:0] next_send_q, next_send_d;
  logic             send_vld_q, send_vld_d;
  logic [TimeW-1:0] pause_start_q, pause_start_d;
  logic [TimeW-1:0] pause_len_q, pause_len_d;
  logic             pause_act_q, pause_act_d;
  logic             worked_q, worked_d;
  logic [ValW-1:0]  stored_q, stored_d;
  logic             present_q, present_d;

  logic [TimeW-1:0] start_time;
  logic [TimeW-1:0] since_read, since_pause, since_send;
  logic             send_due;
  logic             send;

  assign start_time  = item_i.now_ms + cfg_i.warmup_ms - cfg_i.read_interval_ms;
  assign since_read  = item_i.now_ms - last_read_q;
  assign since_pause = item_i.now_ms - pause_start_q;
  assign since_send  = item_i.now_ms - next_send_q;
  assign send_due    = (since_send != '0) && !since_send[TimeW-1];

  always_comb begin
    phase_d       = phase_q;
    active_d      = active_q;
    last_read_d   = last_read_q;
    next_send_d   = next_send_q;
    send_vld_d    = send_vld_q;
    pause_start_d = pause_start_q;
    pause_len_d   = pause_len_q;
    pause_act_d   = pause_act_q;
    worked_d      = worked_q;
    stored_d      = stored_q;
    present_d     = present_q;
    send          = 1'b0;
    unique case (item_i.op)
      OP_START: begin
        active_d    = 1'b1;
        phase_d     = PH_WAIT;
        last_read_d = start_time;
        next_send_d = '0;
        send_vld_d  = 1'b0;
      end
      OP_TERM: begin
        active_d = 1'b0;
        if (phase_q == PH_READ && worked_q && cfg_i.restart_enable) begin
          active_d    = 1'b1;
          phase_d     = PH_WAIT;
          last_read_d = start_time;
          next_send_d = '0;
          send_vld_d  = 1'b0;
        end
      end
      OP_SETWAIT: begin
        pause_act_d   = 1'b1;
        pause_start_d = item_i.now_ms;
        pause_len_d   = item_i.pause_ms;
      end
      OP_LOOP: begin
        if (active_q) begin
          if (pause_act_q) begin
            if (since_pause >= pause_len_q) pause_act_d = 1'b0;
          end else begin
            unique case (phase_q)
              PH_WAIT: begin
                if (since_read >= cfg_i.read_interval_ms) phase_d = PH_READ;
              end
              PH_READ: begin
                if (item_i.probe_done) begin
                  if (item_i.probe_has_value) begin
                    worked_d = 1'b1;
                    if (!present_q || item_i.probe_value != stored_q) begin
                      stored_d    = item_i.probe_value;
                      present_d   = 1'b1;
                      next_send_d = item_i.now_ms;
                      send_vld_d  = 1'b1;
                      phase_d     = PH_SEND;
                    end
                  end else if (send_vld_q && send_due) begin
                    phase_d = PH_SEND;
                  end else begin
                    last_read_d = item_i.now_ms;
                    phase_d     = PH_WAIT;
                  end
                end
              end
              PH_SEND: begin
                send        = present_q;
                last_read_d = item_i.now_ms;
                if (cfg_i.resend_interval_ms != '0) begin
                  next_send_d = item_i.now_ms + cfg_i.resend_interval_ms;
                  send_vld_d  = 1'b1;
                end else begin
                  next_send_d = '0;
                  send_vld_d  = 1'b0;
                end
                phase_d = PH_WAIT;
              end
              PH_OFF: ;
              default: ;
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_OFF;
      active_q      <= 1'b0;
      last_read_q   <= '0;
      next_send_q   <= '0;
      send_vld_q    <= 1'b0;
      pause_start_q <= '0;
      pause_len_q   <= '0;
      pause_act_q   <= 1'b0;
      worked_q      <= 1'b0;
      stored_q      <= '0;
      present_q     <= 1'b0;
    end else if (step_i) begin
      phase_q       <= phase_d;
      active_q      <= active_d;
      last_read_q   <= last_read_d;
      next_send_q   <= next_send_d;
      send_vld_q    <= send_vld_d;
      pause_start_q <= pause_start_d;
      pause_len_q   <= pause_len_d;
      pause_act_q   <= pause_act_d;
      worked_q      <= worked_d;
      stored_q      <= stored_d;
      present_q     <= present_d;
    end
  end

  assign res_o.send_now   = send;
  assign res_o.send_value = send ? stored_q : '0;
  assign res_o.phase      = phase_d;
  assign res_o.pausing    = pause_act_d;
  assign res_o.active     = active_d;

  `SPS_ASSERT_NOW(a_send_from_send_phase, step_i && send,
                  phase_q == PH_SEND && present_q && active_q && !pause_act_q)
  `SPS_ASSERT_NEXT(a_start_enters_wait, step_i && item_i.op == OP_START,
                   active_q && phase_q == PH_WAIT && !send_vld_q)
  `SPS_ASSERT_NEXT(a_setwait_pauses, step_i && item_i.op == OP_SETWAIT, pause_act_q)
  `SPS_ASSERT_NEXT(a_idle_holds, !step_i, $stable(phase_q) && $stable(stored_q))

endmodule
`default_nettype wire

// ===== sv/sensor_poll_scheduler.sv =====
// Sensor poll scheduler: item input, step logic and a one-entry output register.
// Sensor poll scheduler top level. Depends on sps_pkg, sps_cfg_regs and sps_core.
//
// Input channel: in_valid_i / in_stall_o with op, now_ms, probe and pause fields.
// Output channel: out_valid_o / out_stall_i; exactly one result per input item.
// Config channel: cfg_valid_i / cfg_ready_o, index and data; write only when idle.
// A transfer on the input lands in the input register; once the output is free
// (empty or not stalled) the step logic updates the scheduler state and loads
// the result register, which offers the result. One item per cycle is sustained
// while the receiver does not stall; the input register takes a new item in the
// same cycle its item advances.
// When the receiver stalls, the result register holds and the input register
// still holds one item, after which in_stall_o rises; it falls the cycle the
// stalled result is taken.
// Reset clears all scheduler state (phase off, inactive, no pause, nothing stored),
// the config registers and both valid flags; input and result registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module sensor_poll_scheduler (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [sps_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [sps_pkg::TimeW-1:0]   cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [1:0]                  op_i,
  input  wire logic [sps_pkg::TimeW-1:0]   now_ms_i,
  input  wire logic                        probe_done_i,
  input  wire logic                        probe_has_value_i,
  input  wire logic [sps_pkg::ValW-1:0]    probe_value_i,
  input  wire logic [sps_pkg::TimeW-1:0]   pause_ms_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             send_now_o,
  output logic [sps_pkg::ValW-1:0]         send_value_o,
  output logic [1:0]                       phase_o,
  output logic                             pausing_o,
  output logic                             active_o
);
  import sps_pkg::*;

  cfg_t  cfg;
  item_t item_q;
  res_t  res, res_q;
  logic  in_vld_q, out_vld_q;
  logic  advance, in_take;

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  sps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sps_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= '{op: op_i, now_ms: now_ms_i, probe_done: probe_done_i,
                  probe_has_value: probe_has_value_i, probe_value: probe_value_i,
                  pause_ms: pause_ms_i};
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign send_now_o   = res_q.send_now;
  assign send_value_o = res_q.send_value;
  assign phase_o      = res_q.phase;
  assign pausing_o    = res_q.pausing;
  assign active_o     = res_q.active;

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for sensor_poll_scheduler: directed and random operation streams.
// Depends on sps_pkg and the RTL; a scoreboard class tracks the scheduler state and checks results.
`timescale 1ns / 1ps
module tb_top;
  import sps_pkg::*;

  class schedule_tracker;
    logic [31:0] rd_ivl, resend_ivl, warmup;
    logic        restart_en;
    logic [1:0]  phase_q;
    bit          active_q, send_due_vld, pause_on, worked, have_val;
    logic [31:0] last_read, send_due, pause_start, pause_len, held_val;
    res_t        step_results_q[$];
    int          errors;

    function new();
      rd_ivl = '0; resend_ivl = '0; warmup = '0; restart_en = 1'b0;
      phase_q = PH_OFF; active_q = 0; send_due_vld = 0; pause_on = 0;
      worked = 0; have_val = 0;
      last_read = '0; send_due = '0; pause_start = '0; pause_len = '0; held_val = '0;
      errors = 0;
    endfunction

    function void set_cfg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
      case (idx)
        CFG_READ_INTERVAL:   rd_ivl = data;
        CFG_RESEND_INTERVAL: resend_ivl = data;
        CFG_WARMUP:          warmup = data;
        default:             restart_en = data[0];
      endcase
    endfunction

    function void begin_cycle(logic [31:0] now);
      active_q = 1;
      phase_q = PH_WAIT;
      last_read = now + warmup - rd_ivl;
      send_due = '0;
      send_due_vld = 0;
    endfunction

    // next scheduler state and the report it issues for one operation
    function res_t advance_schedule(item_t it);
      res_t        r;
      logic [31:0] d;
      r = '0;
      case (it.op)
        OP_START: begin_cycle(it.now_ms);
        OP_TERM: begin
          active_q = 0;
          if (phase_q == PH_READ && worked && restart_en) begin_cycle(it.now_ms);
        end
        OP_SETWAIT: begin
          pause_on = 1;
          pause_start = it.now_ms;
          pause_len = it.pause_ms;
        end
        default: begin
          if (active_q) begin
            if (pause_on) begin
              d = it.now_ms - pause_start;
              if (d >= pause_len) pause_on = 0;
            end else if (phase_q == PH_WAIT) begin
              d = it.now_ms - last_read;
              if (d >= rd_ivl) phase_q = PH_READ;
            end else if (phase_q == PH_READ) begin
              d = it.now_ms - send_due;
              if (it.probe_done) begin
                if (it.probe_has_value) begin
                  worked = 1;
                  if (!have_val || it.probe_value != held_val) begin
                    held_val = it.probe_value;
                    have_val = 1;
                    send_due = it.now_ms;
                    send_due_vld = 1;
                    phase_q = PH_SEND;
                  end
                end else if (send_due_vld && d != 0 && !d[31]) begin
                  phase_q = PH_SEND;
                end else begin
                  last_read = it.now_ms;
                  phase_q = PH_WAIT;
                end
              end
            end else if (phase_q == PH_SEND) begin
              if (have_val) begin
                r.send_now = 1'b1;
                r.send_value = held_val;
              end
              last_read = it.now_ms;
              send_due_vld = (resend_ivl != 0);
              send_due = send_due_vld ? it.now_ms + resend_ivl : '0;
              phase_q = PH_WAIT;
            end
          end
        end
      endcase
      r.phase = phase_q;
      r.pausing = pause_on;
      r.active = active_q;
      return r;
    endfunction

    function void log_item(item_t it);
      step_results_q.push_back(advance_schedule(it));
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    task check_result(res_t got);
      res_t want;
      if (step_results_q.size() == 0) begin
        report("result transfer with nothing outstanding");
      end else begin
        want = step_results_q.pop_front();
        if (got.send_now !== want.send_now)
          report($sformatf("send_now %0b, want %0b", got.send_now, want.send_now));
        if (got.send_value !== want.send_value)
          report($sformatf("send_value %h, want %h", got.send_value, want.send_value));
        if (got.phase !== want.phase)
          report($sformatf("phase %0d, want %0d", got.phase, want.phase));
        if (got.pausing !== want.pausing)
          report($sformatf("pausing %0b, want %0b", got.pausing, want.pausing));
        if (got.active !== want.active)
          report($sformatf("active %0b, want %0b", got.active, want.active));
      end
    endtask
  endclass

  logic                 clk_i, rst_ni;
  logic                 cfg_valid, cfg_ready;
  logic [CfgIdxW-1:0]   cfg_index;
  logic [31:0]          cfg_data;
  logic                 in_valid, in_stall;
  item_t                in_item;
  logic                 out_valid, out_stall;
  logic                 send_now, pausing, active;
  logic [31:0]          send_value;
  logic [1:0]           phase;

  schedule_tracker tracker;
  int          send_idle_pct, recv_idle_pct, hold_cycles;
  logic [31:0] clock_ms;
  logic [31:0] val_pool[3];
  bit          session_on;

  sensor_poll_scheduler dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .op_i              (in_item.op),
    .now_ms_i          (in_item.now_ms),
    .probe_done_i      (in_item.probe_done),
    .probe_has_value_i (in_item.probe_has_value),
    .probe_value_i     (in_item.probe_value),
    .pause_ms_i        (in_item.pause_ms),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .send_now_o        (send_now),
    .send_value_o      (send_value),
    .phase_o           (phase),
    .pausing_o         (pausing),
    .active_o          (active)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(100_000 * 12);
    $display("sensor_poll_scheduler verification failed");
    $finish;
  end

  // result side: checks at the rising edge, stall decided at the falling edge
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid && !out_stall)
        tracker.check_result({send_now, send_value, phase, pausing, active});
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    tracker.set_cfg(idx, data);
  endtask

  task automatic load_config(input logic [31:0] rd, rs, wu, input logic re);
    write_reg(CFG_READ_INTERVAL, rd);
    write_reg(CFG_RESEND_INTERVAL, rs);
    write_reg(CFG_WARMUP, wu);
    write_reg(CFG_RESTART_ENABLE, {31'd0, re});
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (in_stall);
    tracker.log_item(it);
  endtask

  task automatic op_item(input logic [1:0] op, input logic [31:0] now,
                         input logic done, hv, input logic [31:0] val, pause);
    item_t it;
    it = '{op, now, done, hv, val, pause};
    push_item(it);
  endtask

  task automatic drain;
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (tracker.step_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(input int n, input int step_max, input bit long_hold,
                           input bit sender_pause);
    item_t it;
    int    roll;
    for (int i = 0; i < n; i++) begin
      if (long_hold && i == n / 3) hold_cycles = 80;
      if (sender_pause && i == n / 2) begin
        @(negedge clk_i);
        in_valid <= 1'b0;
        while (tracker.step_results_q.size() != 0) @(posedge clk_i);
      end
      roll = $urandom_range(99);
      if (roll < 3)       clock_ms += $urandom();
      else if (roll < 10) clock_ms += 0;
      else                clock_ms += $urandom_range(1, step_max);
      if ($urandom_range(99) < 5) val_pool[$urandom_range(2)] = $urandom();
      it.op = OP_LOOP;
      it.now_ms = clock_ms;
      it.probe_done = ($urandom_range(99) < 55);
      it.probe_has_value = ($urandom_range(99) < 70);
      it.probe_value = ($urandom_range(99) < 85) ? val_pool[$urandom_range(2)] : $urandom();
      it.pause_ms = $urandom();
      roll = $urandom_range(99);
      if (!session_on) begin
        if (roll < 70) begin
          it.op = OP_START;
        end else begin
          it = '{$urandom_range(3), $urandom(), $urandom_range(1), $urandom_range(1),
                 $urandom(), $urandom()};
        end
        session_on = (it.op == OP_START);
      end else if (roll < 6) begin
        it.op = OP_TERM;
        session_on = 0;
      end else if (roll < 11) begin
        it.op = OP_SETWAIT;
        roll = $urandom_range(99);
        if (roll < 70)      it.pause_ms = $urandom_range(0, 3 * step_max);
        else if (roll < 90) it.pause_ms = $urandom();
        else                it.pause_ms = '0;
      end else if (roll < 14) begin
        it.op = OP_START;
      end else if (roll < 17) begin
        it = '{$urandom_range(3), $urandom(), $urandom_range(1), $urandom_range(1),
               $urandom(), $urandom()};
      end
      push_item(it);
    end
    drain();
  endtask

  initial begin
    tracker = new();
    rst_ni = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_item = '0;
    hold_cycles = 0;
    send_idle_pct = 23;
    recv_idle_pct = 61;
    clock_ms = '0;
    session_on = 0;
    val_pool[0] = 32'h0000_0000;
    val_pool[1] = 32'hFFFF_FFFF;
    val_pool[2] = 32'h5A5A_A5A5;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed walk through every phase and operation
    load_config(32'd4, 32'd16, 32'd2, 1'b1);
    op_item(OP_LOOP,    32'd0,  1, 1, 32'h1234_5678, 32'd0);
    op_item(OP_TERM,    32'd1,  0, 0, 32'd0, 32'd0);
    op_item(OP_SETWAIT, 32'd5,  0, 0, 32'd0, 32'd3);
    op_item(OP_LOOP,    32'd7,  0, 0, 32'd0, 32'd0);
    op_item(OP_START,   32'd10, 0, 0, 32'd0, 32'd0);
    op_item(OP_LOOP,    32'd11, 0, 0, 32'd0, 32'd0);
    op_item(OP_LOOP,    32'd11, 0, 0, 32'd0, 32'd0);
    op_item(OP_LOOP,    32'd12, 0, 0, 32'd0, 32'd0);
    op_item(OP_LOOP,    32'd12, 0, 1, 32'd7, 32'd0);
    op_item(OP_LOOP,    32'd13, 1, 0, 32'd0, 32'd0);
    op_item(OP_LOOP,    32'd17, 0, 0, 32'd0, 32'd0);
    op_item(OP_LOOP,    32'd18, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    op_item(OP_LOOP,    32'd18, 0, 0, 32'd0, 32'd0);
    op_item(OP_LOOP,    32'd22, 0, 0, 32'd0, 32'd0);
    op_item(OP_LOOP,    32'd22, 1, 1, 32'hFFFF_FFFF, 32'd0);
    op_item(OP_LOOP,    32'd34, 1, 0, 32'd0, 32'd0);
    op_item(OP_LOOP,    32'd40, 0, 0, 32'd0, 32'd0);
    op_item(OP_LOOP,    32'd40, 1, 0, 32'd0, 32'd0);
    op_item(OP_LOOP,    32'd40, 0, 0, 32'd0, 32'd0);
    op_item(OP_LOOP,    32'd44, 0, 0, 32'd0, 32'd0);
    op_item(OP_TERM,    32'd44, 0, 0, 32'd0, 32'd0);
    op_item(OP_SETWAIT, 32'd45, 0, 0, 32'd0, 32'hFFFF_FFFF);
    op_item(OP_LOOP,    32'd46, 0, 0, 32'd0, 32'd0);
    op_item(OP_SETWAIT, 32'hFFFF_FFFE, 0, 0, 32'd0, 32'd0);
    op_item(OP_LOOP,    32'hFFFF_FFFE, 0, 0, 32'd0, 32'd0);
    op_item(OP_START,   32'hFFFF_FFFF, 1, 1, 32'd0, 32'd0);
    drain();
    clock_ms = 32'hFFFF_FFFF;

    load_config(32'd0, 32'd0, 32'd0, 1'b0);
    run_phase(90, 6, 0, 0);
    load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    run_phase(90, 20, 0, 0);

    send_idle_pct = 61;
    recv_idle_pct = 23;
    load_config($urandom_range(1, 30), $urandom_range(1, 60), $urandom_range(0, 30),
                $urandom_range(1));
    run_phase(90, 12, 1, 0);
    load_config(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 1'b0);
    run_phase(90, 20, 0, 0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_config($urandom_range(1, 30), $urandom_range(1, 60), $urandom_range(0, 30), 1'b1);
    run_phase(90, 12, 0, 1);

    repeat (6) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("sensor_poll_scheduler verification clean");
    end else begin
      $display("sensor_poll_scheduler verification failed");
    end
    $finish;
  end

endmodule
